>>> rtl/core/spatial_grid_bucket_table_unit_defines.svh
// Assertion helpers for the grid bucket table
`ifndef SPATIAL_GRID_BUCKET_TABLE_UNIT_DEFINES_SVH
`define SPATIAL_GRID_BUCKET_TABLE_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define SGB_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication checked outside reset
`define SGB_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> rtl/core/sgb_pkg.sv
package sgb_pkg;

   localparam int CellsDefault      = 1024;
   localparam int SlotsDefault      = 16;
   localparam int HandleBitsDefault = 16;

   localparam int PosBits = 20;
   localparam int DivBits = 16;
   localparam int QuoBits = 19;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StNegative = 3'd1;
   localparam logic [2:0] StOutside  = 3'd2;
   localparam logic [2:0] StFull     = 3'd3;
   localparam logic [2:0] StNotFound = 3'd4;

   localparam logic CmdInsert = 1'b0;
   localparam logic CmdRemove = 1'b1;

   localparam logic [1:0] CsrCellSize = 2'd0;
   localparam logic [1:0] CsrColumns  = 2'd1;
   localparam logic [1:0] CsrRows     = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic        [15:0] handle;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] cell_index;
      logic [4:0] cell_count;
   } rsp_type;

endpackage

>>> rtl/core/spatial_grid_bucket_table_unit.sv
// Channel   | Handshake               | Payload
// req       | start & !busy           | req_data (cmd, pos_x, pos_y, handle)
// rsp       | rsp_strobe, one cycle   | rsp_data (status, cell_index, cell_count)
// csr       | csr_valid & csr_ready   | csr_index, csr_wdata
//
// An insert runs the bit-serial divider, then forms the index, hands off through the
// queue and ends in the back; no new request is taken until it is through.
// A remove also reads and compares each slot it visits; a negative position skips the
// divider, and a cell outside the grid skips the lookup in the back.
// After reset the back clears the slot count of every cell, with busy high.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "spatial_grid_bucket_table_unit_defines.svh"
module spatial_grid_bucket_table_unit import sgb_pkg::*; #(
   parameter int CELLS       = CellsDefault,
   parameter int SLOTS       = SlotsDefault,
   parameter int HANDLE_BITS = HandleBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] cell_size_ff;
   logic [10:0] grid_columns_ff, grid_rows_ff;

   logic        f_ready, f_valid, f_cmd, q_ready, q_valid, b_ready, b_busy;
   logic [15:0] f_handle;
   logic [2:0]  f_status;
   logic [31:0] f_index;
   logic [51:0] q_data;

   assign csr_ready = 1'b1;
   // hold off new commands while the front, queue or back holds work
   assign busy = !f_ready || q_valid || b_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff    <= 16'd512;
         grid_columns_ff <= 11'd32;
         grid_rows_ff    <= 11'd32;
      end else if (csr_valid) begin
         case (csr_index)
            CsrCellSize: cell_size_ff    <= csr_wdata;
            CsrColumns:  grid_columns_ff <= csr_wdata[10:0];
            CsrRows:     grid_rows_ff    <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   sgb_front #(.CELLS(CELLS)) u_front (
      .clock, .reset,
      .in_valid(start && !busy), .in_req(req_data), .in_ready(f_ready),
      .cell_size(cell_size_ff), .grid_columns(grid_columns_ff),
      .grid_rows(grid_rows_ff),
      .out_valid(f_valid), .out_cmd(f_cmd), .out_handle(f_handle),
      .out_status(f_status), .out_index(f_index), .out_ready(q_ready)
   );

   // queue word: cmd, handle, cell index, spare, status
   sgb_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_data({f_cmd, f_handle, f_index[15:0], 16'd0, f_status}),
      .wr_ready(q_ready),
      .rd_valid(q_valid), .rd_data(q_data), .rd_ready(b_ready)
   );

   sgb_back #(.CELLS(CELLS), .SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_data(q_data), .in_ready(b_ready), .busy(b_busy),
      .rsp_valid(rsp_strobe), .rsp_data(rsp_data)
   );

   `SGB_ASSERT_NEXT(a_one_result, clock, reset, rsp_strobe, !rsp_strobe, "result repeated")
   `SGB_ASSERT_IMP(a_ok_count, clock, reset, rsp_strobe && rsp_data.status == StNegative,
      rsp_data.cell_count == 5'd0, "bad count on negative")
   `SGB_ASSERT_IMP(a_accept_idle, clock, reset, start && !busy, f_ready, "front not idle")

endmodule

>>> rtl/core/sgb_front.sv
// Front: check sign, divide both coordinates, bound-check, form the cell index.
module sgb_front import sgb_pkg::*; #(
   parameter int CELLS = CellsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_req,
   output logic        in_ready,
   input  logic [15:0] cell_size,
   input  logic [10:0] grid_columns,
   input  logic [10:0] grid_rows,
   output logic        out_valid,
   output logic        out_cmd,
   output logic [15:0] out_handle,
   output logic [2:0]  out_status,
   output logic [31:0] out_index,
   input  logic        out_ready
);

   typedef enum logic [1:0] {FIdle, FDiv, FIdx, FHold} fstate_type;

   fstate_type  state_ff;
   logic [4:0]  step_ff;
   logic [18:0] qx_ff, qy_ff;
   logic [16:0] rx_ff, ry_ff;
   logic [15:0] div_ff;
   logic        cmd_ff;
   logic [15:0] handle_ff;
   logic [2:0]  status_ff;
   logic [31:0] index_ff;

   logic [16:0] rx_sh, ry_sh;
   logic        gx, gy;
   logic [21:0] prod;

   // one restoring-division bit per cycle for both coordinates
   always_comb begin
      rx_sh = {rx_ff[15:0], qx_ff[18]};
      ry_sh = {ry_ff[15:0], qy_ff[18]};
      gx    = rx_sh >= {1'b0, div_ff};
      gy    = ry_sh >= {1'b0, div_ff};
      prod  = 22'(qy_ff[10:0]) * 22'(grid_columns);
   end

   assign in_ready   = (state_ff == FIdle);
   assign out_valid  = (state_ff == FHold);
   assign out_cmd    = cmd_ff;
   assign out_handle = handle_ff;
   assign out_status = status_ff;
   assign out_index  = index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIdle;
      end else begin
         case (state_ff)
            FIdle: begin
               if (in_valid) begin
                  cmd_ff    <= in_req.cmd;
                  handle_ff <= in_req.handle;
                  qx_ff     <= in_req.pos_x[18:0];
                  qy_ff     <= in_req.pos_y[18:0];
                  rx_ff     <= '0;
                  ry_ff     <= '0;
                  div_ff    <= (cell_size == 16'd0) ? 16'd1 : cell_size;
                  step_ff   <= '0;
                  index_ff  <= '0;
                  if (in_req.pos_x[19] || in_req.pos_y[19]) begin
                     status_ff <= StNegative;
                     state_ff  <= FHold;
                  end else begin
                     status_ff <= StOk;
                     state_ff  <= FDiv;
                  end
               end
            end
            FDiv: begin
               qx_ff   <= {qx_ff[17:0], gx};
               qy_ff   <= {qy_ff[17:0], gy};
               rx_ff   <= gx ? rx_sh - {1'b0, div_ff} : rx_sh;
               ry_ff   <= gy ? ry_sh - {1'b0, div_ff} : ry_sh;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(QuoBits - 1)) state_ff <= FIdx;
            end
            FIdx: begin
               if (qx_ff >= 19'(grid_columns) || qy_ff >= 19'(grid_rows) ||
                   (32'(prod) + 32'(qx_ff)) >= 32'(CELLS)) begin
                  status_ff <= StOutside;
               end
               index_ff <= 32'(prod) + 32'(qx_ff);
               state_ff <= FHold;
            end
            FHold: if (out_ready) state_ff <= FIdle;
            default: state_ff <= FIdle;
         endcase
      end
   end

endmodule

>>> rtl/core/sgb_queue.sv
// Two-entry queue between front and back.
module sgb_queue import sgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   input  logic [51:0] wr_data,
   output logic        wr_ready,
   output logic        rd_valid,
   output logic [51:0] rd_data,
   input  logic        rd_ready
);

   logic [51:0] mem_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> rtl/core/sgb_back.sv
// Back: clear counts, then insert or search-and-compact one cell, or pass on an error status.
module sgb_back import sgb_pkg::*; #(
   parameter int CELLS       = CellsDefault,
   parameter int SLOTS       = SlotsDefault,
   parameter int HANDLE_BITS = HandleBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [51:0] in_data,
   output logic        in_ready,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {BClear, BIdle, BCnt, BDecide, BRead, BComp, BShift} bstate_type;

   bstate_type             state_ff;
   logic [CW-1:0]          cell_ff;
   logic [CW:0]            clr_ff;
   logic [NW-1:0]          cnt_ff;
   logic [SW:0]            i_ff;
   logic                   cmd_ff;
   logic [HANDLE_BITS-1:0] h_ff;
   logic                   found_ff;

   logic [NW-1:0]          counts [CELLS];
   logic [HANDLE_BITS-1:0] entries [CELLS*SLOTS];
   logic [NW-1:0]          cnt_rd_ff;
   logic [HANDLE_BITS-1:0] ent_rd_ff;

   logic                   c_we, e_we;
   logic [CW-1:0]          c_wa;
   logic [NW-1:0]          c_wd;
   logic [CW+SW-1:0]       e_wa, e_ra;
   logic [HANDLE_BITS-1:0] e_wd;
   logic [CW-1:0]          in_cell;

   assign in_cell  = in_data[19+CW-1:19];
   assign in_ready = (state_ff == BIdle);
   assign busy     = (state_ff != BIdle);

   always_ff @(posedge clock) begin
      if (c_we) counts[c_wa] <= c_wd;
      cnt_rd_ff <= counts[cell_ff];
      if (e_we) entries[e_wa] <= e_wd;
      ent_rd_ff <= entries[e_ra];
   end

   always_comb begin
      c_we = 1'b0;
      c_wa = cell_ff;
      c_wd = cnt_ff;
      e_we = 1'b0;
      e_wa = {cell_ff, i_ff[SW-1:0]};
      e_wd = h_ff;
      e_ra = {cell_ff, i_ff[SW-1:0]};
      case (state_ff)
         BClear: begin
            c_we = 1'b1;
            c_wa = clr_ff[CW-1:0];
            c_wd = '0;
         end
         BDecide: begin
            if (cmd_ff == CmdInsert && cnt_rd_ff < NW'(SLOTS)) begin
               e_we = 1'b1;
               e_wa = {cell_ff, cnt_rd_ff[SW-1:0]};
               c_we = 1'b1;
               c_wd = cnt_rd_ff + NW'(1);
            end
         end
         BShift: begin
            e_we = 1'b1;
            e_wa = {cell_ff, SW'(i_ff - 1'b1)};
            e_wd = ent_rd_ff;
            if ((SW+1)'(i_ff + 1'b1) >= (SW+1)'(cnt_ff)) begin
               c_we = 1'b1;
               c_wd = cnt_ff - NW'(1);
            end
         end
         BComp: begin
            if (ent_rd_ff == h_ff && (SW+1)'(i_ff + 1'b1) >= (SW+1)'(cnt_ff)) begin
               c_we = 1'b1;
               c_wd = cnt_ff - NW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff  <= BClear;
         clr_ff    <= '0;
      end else begin
         case (state_ff)
            BClear: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (CW+1)'(CELLS - 1)) state_ff <= BIdle;
            end
            BIdle: begin
               if (in_valid) begin
                  cmd_ff  <= in_data[51];
                  h_ff    <= HANDLE_BITS'(in_data[50:35]);
                  cell_ff <= in_cell;
                  if (in_data[2:0] != StOk) begin
                     rsp_valid  <= 1'b1;
                     rsp_data   <= '{in_data[2:0], 10'd0, 5'd0};
                  end else begin
                     state_ff <= BCnt;
                  end
               end
            end
            BCnt: state_ff <= BDecide;
            BDecide: begin
               cnt_ff   <= cnt_rd_ff;
               i_ff     <= '0;
               found_ff <= 1'b0;
               if (cmd_ff == CmdInsert) begin
                  rsp_valid <= 1'b1;
                  rsp_data  <= (cnt_rd_ff < NW'(SLOTS)) ?
                     '{StOk, 10'(cell_ff), 5'(cnt_rd_ff + NW'(1))} :
                     '{StFull, 10'(cell_ff), 5'(cnt_rd_ff)};
                  state_ff  <= BIdle;
               end else if (cnt_rd_ff == '0) begin
                  rsp_valid <= 1'b1;
                  rsp_data  <= '{StNotFound, 10'(cell_ff), 5'd0};
                  state_ff  <= BIdle;
               end else begin
                  state_ff <= BRead;
               end
            end
            BRead: state_ff <= found_ff ? BShift : BComp;
            BComp: begin
               if (ent_rd_ff == h_ff || found_ff) begin
                  found_ff <= 1'b1;
                  if ((SW+1)'(i_ff + 1'b1) >= (SW+1)'(cnt_ff)) begin
                     rsp_valid <= 1'b1;
                     rsp_data  <= '{StOk, 10'(cell_ff), 5'(cnt_ff - NW'(1))};
                     state_ff  <= BIdle;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= BRead;
                  end
               end else if ((SW+1)'(i_ff + 1'b1) >= (SW+1)'(cnt_ff)) begin
                  rsp_valid <= 1'b1;
                  rsp_data  <= '{StNotFound, 10'(cell_ff), 5'(cnt_ff)};
                  state_ff  <= BIdle;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= BRead;
               end
            end
            BShift: begin
               if ((SW+1)'(i_ff + 1'b1) >= (SW+1)'(cnt_ff)) begin
                  rsp_valid <= 1'b1;
                  rsp_data  <= '{StOk, 10'(cell_ff), 5'(cnt_ff - NW'(1))};
                  state_ff  <= BIdle;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= BRead;
               end
            end
            default: state_ff <= BIdle;
         endcase
      end
   end

endmodule
